### hw/rtl/teoc_pkg.sv
// Shared types, constants and a helper function for the TLB entry overlap checker.
package teoc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PAGE_W        = 42;
  localparam int unsigned EPN_W         = 20;
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned SEL_W         = 4;
  localparam int unsigned TID_W         = 12;
  localparam int unsigned PERM_W        = 10;
  localparam int unsigned WIMGE_W       = 7;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned VALUE_W       = 31;
  localparam int unsigned MIN_PAGE_LOG2 = 10;
  localparam int unsigned MAX_SEL       = 15;
  localparam int unsigned MAX_BYTE_SEL  = 10;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SEL   = 2'd0,
    KIND_BYTES = 2'd1,
    KIND_OFF   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BADARG   = 3'd1,
    STS_BADSEL   = 3'd2,
    STS_MISALIGN = 3'd3,
    STS_NOTREADY = 3'd4,
    STS_OVERLAP  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_SET   = 2'd1,
    WR_INVAL = 2'd2
  } wr_op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [PAGE_W-1:0] last;
    logic              space;
    logic [TID_W-1:0]  tid;
    logic              skip_en;
    logic [IDX_W-1:0]  skip_idx;
  } query_t;

  typedef struct packed {
    logic               en;
    logic               set;
    logic [IDX_W-1:0]   idx;
    logic               space;
    logic [TID_W-1:0]   tid;
    logic [EPN_W-1:0]   epn;
    logic [SEL_W-1:0]   sel;
    logic [EPN_W-1:0]   rpn;
    logic [PERM_W-1:0]  perm;
    logic [WIMGE_W-1:0] wimge;
  } wr_t;

  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } tok_t;

  function automatic logic [PAGE_W-1:0] page_mask(logic [SEL_W-1:0] sel);
    return (PAGE_W'(1) << (MIN_PAGE_LOG2 + 2 * int'(sel))) - PAGE_W'(1);
  endfunction

endpackage

### hw/rtl/tlb_entry_overlap_checker.sv
// Top level of the TLB entry overlap checker: command decode, sequencer and cell chain.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   cmd_i ... wimge_i
//   out      output     out_valid_o/out_ready_i status_o, hit_o, hit_index_o
//   cfg      input      cfg_we_i                cfg_wdata_i (driver ready)
//
// A write that passes its checks and enables an entry, and a check that passes its checks,
// scan the cell chain, one token passing one cell per cycle. Any other transaction skips
// the scan and goes straight from idle to the finish state.
// One transaction is in flight at a time; a new one is accepted while the last result waits.
// Reset clears every entry's valid bit and the driver ready register at once.
// A stalled result holds the sequencer in its finish state until the result is taken.
module tlb_entry_overlap_checker #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] eff_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [1:0]  size_kind_i,
  input  logic [30:0] size_value_i,
  input  logic        space_i,
  input  logic [11:0] tid_i,
  input  logic [9:0]  perm_i,
  input  logic [6:0]  wimge_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        hit_o,
  output logic [3:0]  hit_index_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import teoc_pkg::*;

  state_e             state_q, state_d;
  logic               driver_ready_q;
  logic               launch_q;
  logic               out_valid_q;

  logic               dec_ok;
  status_e            dec_status;
  logic [SEL_W-1:0]   dec_sel;
  logic               dec_off;
  logic [PAGE_W-1:0]  dec_mask;
  logic               mis_ea;
  logic               mis_pa;
  logic               idx_bad;

  status_e            acc_status;
  logic               acc_scan;
  logic               acc_skip;
  wr_op_e             acc_op;
  logic               accept;
  logic               out_free;
  logic               fin;

  query_t             query_q;
  status_e            req_status_q;
  wr_op_e             req_op_q;
  logic [IDX_W-1:0]   req_idx_q;
  logic [SEL_W-1:0]   req_sel_q;
  logic [EPN_W-1:0]   req_epn_q;
  logic [EPN_W-1:0]   req_rpn_q;
  logic [PERM_W-1:0]  req_perm_q;
  logic [WIMGE_W-1:0] req_wimge_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;

  logic [2:0]         status_q;
  logic               hit_out_q;
  logic [IDX_W-1:0]   hit_index_q;

  wr_t                wr;
  tok_t               tok [ENTRIES+1];

  always_comb begin
    dec_ok     = 1'b1;
    dec_status = STS_OK;
    dec_sel    = '0;
    dec_off    = 1'b0;
    unique case (kind_e'(size_kind_i))
      KIND_SEL: begin
        if (size_value_i > VALUE_W'(MAX_SEL)) begin
          dec_ok     = 1'b0;
          dec_status = STS_BADSEL;
        end else begin
          dec_sel = size_value_i[SEL_W-1:0];
        end
      end
      KIND_BYTES: begin
        dec_ok     = 1'b0;
        dec_status = STS_BADARG;
        for (int k = 0; k <= MAX_BYTE_SEL; k++) begin
          if (size_value_i == (VALUE_W'(1) << (MIN_PAGE_LOG2 + 2 * k))) begin
            dec_ok     = 1'b1;
            dec_status = STS_OK;
            dec_sel    = SEL_W'(k);
          end
        end
      end
      KIND_OFF: begin
        dec_off = 1'b1;
      end
      default: begin
        dec_ok     = 1'b0;
        dec_status = STS_BADARG;
      end
    endcase
  end

  assign dec_mask = page_mask(dec_sel);
  assign mis_ea   = |(eff_addr_i & dec_mask[ADDR_W-1:0]);
  assign mis_pa   = |(phys_addr_i & dec_mask[ADDR_W-1:0]);
  assign idx_bad  = (32'(entry_index_i) >= 32'(ENTRIES));

  always_comb begin
    acc_status = STS_OK;
    acc_scan   = 1'b0;
    acc_skip   = 1'b0;
    acc_op     = WR_NONE;
    unique case (cmd_e'(cmd_i))
      CMD_WRITE: begin
        priority if (!dec_ok) begin
          acc_status = dec_status;
        end else if (!dec_off && !driver_ready_q) begin
          acc_status = STS_NOTREADY;
        end else if (!dec_off && (mis_ea || mis_pa)) begin
          acc_status = STS_MISALIGN;
        end else if (idx_bad) begin
          acc_status = STS_BADARG;
        end else if (!dec_off) begin
          acc_scan = 1'b1;
          acc_skip = 1'b1;
          acc_op   = WR_SET;
        end else begin
          acc_op = WR_INVAL;
        end
      end
      CMD_CHECK: begin
        priority if (!dec_ok) begin
          acc_status = dec_status;
        end else if (dec_off) begin
          acc_status = STS_BADARG;
        end else if (!driver_ready_q) begin
          acc_status = STS_NOTREADY;
        end else if (mis_ea) begin
          acc_status = STS_MISALIGN;
        end else begin
          acc_scan = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (idx_bad) begin
          acc_status = STS_BADARG;
        end else begin
          acc_op = WR_INVAL;
        end
      end
      default: begin
        acc_status = STS_BADARG;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = acc_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (tok[ENTRIES].vld) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_ready_o && in_valid_i;
    fin        = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      driver_ready_q <= 1'b0;
      launch_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept && acc_scan;
      if (cfg_we_i) begin
        driver_ready_q <= cfg_wdata_i;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q.start    <= eff_addr_i;
      query_q.last     <= PAGE_W'(eff_addr_i) | dec_mask;
      query_q.space    <= space_i;
      query_q.tid      <= tid_i;
      query_q.skip_en  <= acc_skip;
      query_q.skip_idx <= entry_index_i;
      req_status_q     <= acc_status;
      req_op_q         <= acc_op;
      req_idx_q        <= entry_index_i;
      req_sel_q        <= dec_sel;
      req_epn_q        <= eff_addr_i[ADDR_W-1:PAGE_SHIFT];
      req_rpn_q        <= phys_addr_i[ADDR_W-1:PAGE_SHIFT];
      req_perm_q       <= perm_i;
      req_wimge_q      <= wimge_i;
      hit_q            <= 1'b0;
      hit_idx_q        <= '0;
    end else if ((state_q == S_SCAN) && tok[ENTRIES].vld) begin
      hit_q     <= tok[ENTRIES].hit;
      hit_idx_q <= tok[ENTRIES].idx;
    end
    if (fin) begin
      status_q    <= (hit_q && (req_op_q == WR_SET)) ? STS_OVERLAP : req_status_q;
      hit_out_q   <= hit_q;
      hit_index_q <= hit_q ? hit_idx_q : '0;
    end
  end

  always_comb begin
    wr.en    = fin && (req_op_q != WR_NONE) && !((req_op_q == WR_SET) && hit_q);
    wr.set   = (req_op_q == WR_SET);
    wr.idx   = req_idx_q;
    wr.space = query_q.space;
    wr.tid   = query_q.tid;
    wr.epn   = req_epn_q;
    wr.sel   = req_sel_q;
    wr.rpn   = req_rpn_q;
    wr.perm  = req_perm_q;
    wr.wimge = req_wimge_q;
  end

  assign tok[0] = '{vld: launch_q, hit: 1'b0, idx: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    teoc_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (query_q),
      .wr_i    (wr),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_o       = hit_out_q;
  assign hit_index_o = hit_index_q;

endmodule

### hw/rtl/teoc_cell.sv
// One table entry with its overlap compare, one link of the scan chain.
module teoc_cell #(
  parameter int ENTRIES = 16,
  parameter int INDEX   = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  teoc_pkg::query_t query_i,
  input  teoc_pkg::wr_t    wr_i,
  input  teoc_pkg::tok_t   tok_i,
  output teoc_pkg::tok_t   tok_o
);
  import teoc_pkg::*;

  localparam int LOC_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W = (LOC_W > IDX_W) ? LOC_W : IDX_W;

  logic               valid_q;
  logic               space_q;
  logic [TID_W-1:0]   tid_q;
  logic [EPN_W-1:0]   epn_q;
  logic [SEL_W-1:0]   sel_q;
  logic [EPN_W-1:0]   rpn_q;
  logic [PERM_W-1:0]  perm_q;
  logic [WIMGE_W-1:0] wimge_q;

  logic               sel_me;
  logic               skip_me;
  logic [PAGE_W-1:0]  base;
  logic [PAGE_W-1:0]  last;
  logic               match;
  tok_t               tok_d;
  tok_t               tok_q;

  assign sel_me  = (CMP_W'(wr_i.idx) == CMP_W'(INDEX));
  assign skip_me = query_i.skip_en && (CMP_W'(query_i.skip_idx) == CMP_W'(INDEX));
  assign base    = PAGE_W'({epn_q, {PAGE_SHIFT{1'b0}}});
  assign last    = base | page_mask(sel_q);

  always_comb begin
    match = valid_q && !skip_me && (space_q == query_i.space) &&
            ((tid_q == '0) || (tid_q == query_i.tid)) &&
            (PAGE_W'(query_i.start) <= last) && (query_i.last >= base);
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit || match;
    if (!tok_i.hit && match) begin
      tok_d.idx = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      space_q <= 1'b0;
      tid_q   <= '0;
      epn_q   <= '0;
      sel_q   <= '0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.en && sel_me) begin
        valid_q <= wr_i.set;
        if (wr_i.set) begin
          space_q <= wr_i.space;
          tid_q   <= wr_i.tid;
          epn_q   <= wr_i.epn;
          sel_q   <= wr_i.sel;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && sel_me && wr_i.set) begin
      rpn_q   <= wr_i.rpn;
      perm_q  <= wr_i.perm;
      wimge_q <= wr_i.wimge;
    end
  end

  assign tok_o = tok_q;

endmodule

### hw/rtl/teoc_chk.sv
// Port-level assertions for the TLB entry overlap checker and their bind.
module teoc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        hit_o,
  input logic [3:0]  hit_index_o
);
  import teoc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(hit_o) && $stable(hit_index_o))
    else $error("Result changed while stalled.");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_index_o == '0)
    else $error("Hit index set without a hit.");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (status_o == STS_OK) || (status_o == STS_OVERLAP))
    else $error("Hit reported with an error status.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Second transaction accepted while one is in flight.");

endmodule

bind tlb_entry_overlap_checker teoc_chk u_teoc_chk (.*);
